### hdl/gvbm_pkg.sv
package gvbm_pkg;

	localparam int unsigned COORD_W = 4;
	localparam int unsigned SIZE_W  = 5;
	localparam int unsigned ROW_W   = 16;
	localparam int unsigned ADDR_W  = 8;
	localparam int unsigned WORD_W  = 2 * ROW_W;

	localparam logic [1:0] KIND_LOAD  = 2'd0;
	localparam logic [1:0] KIND_CLEAR = 2'd1;
	localparam logic [1:0] KIND_PULL  = 2'd2;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_DUP  = 2'd1;
	localparam logic [1:0] ST_NONE = 2'd2;

	localparam logic [2:0] REG_MERGE_ENABLE = 3'd0;

	typedef struct packed {
		logic [1:0]         kind;
		logic [COORD_W-1:0] cell_x;
		logic [COORD_W-1:0] cell_y;
		logic [COORD_W-1:0] cell_z;
		logic               solid;
		logic               collidable;
	} item_t;

	typedef struct packed {
		logic [1:0]         status;
		logic [COORD_W-1:0] box_x;
		logic [COORD_W-1:0] box_y;
		logic [COORD_W-1:0] box_z;
		logic [SIZE_W-1:0]  size_x;
		logic [SIZE_W-1:0]  size_y;
		logic [SIZE_W-1:0]  size_z;
	} result_t;

	// row word: solid bits in the upper half, collidable bits in the lower half
	typedef struct packed {
		logic              clear;
		logic              we;
		logic [ADDR_W-1:0] addr;
		logic [WORD_W-1:0] wdata;
	} mem_req_t;

	function automatic logic [SIZE_W-1:0] run_len(input logic [ROW_W-1:0] row,
		input logic [COORD_W-1:0] x0);
		logic [ROW_W-1:0]  sh;
		logic [SIZE_W-1:0] n;
		logic              stop;
		sh = row >> x0;
		n = '0;
		stop = 1'b0;
		for (int i = 0; i < ROW_W; i++) begin
			if (!stop && sh[i]) begin
				n = n + SIZE_W'(1);
			end else begin
				stop = 1'b1;
			end
		end
		return n;
	endfunction

	function automatic logic [ROW_W-1:0] span(input logic [COORD_W-1:0] x0,
		input logic [SIZE_W-1:0] ex);
		logic [ROW_W:0] m;
		m = ((ROW_W+1)'(1) << ex) - (ROW_W+1)'(1);
		return m[ROW_W-1:0] << x0;
	endfunction

	function automatic logic [COORD_W:0] low_bit(input logic [ROW_W-1:0] row);
		logic [COORD_W:0] r;
		r = '0;
		for (int i = ROW_W - 1; i >= 0; i--) begin
			if (row[i]) begin
				r = {1'b1, COORD_W'(i)};
			end
		end
		return r;
	endfunction

endpackage

### hdl/gvbm_row_store.sv
module gvbm_row_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  gvbm_pkg::mem_req_t        req,
	output logic [gvbm_pkg::WORD_W-1:0] rdata
);
	import gvbm_pkg::*;

	localparam int unsigned DEPTH = 1 << ADDR_W;

	logic [WORD_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [WORD_W-1:0] rdata_q;
	logic              rvld_q;

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.addr] <= req.wdata;
		end
		rdata_q <= mem[req.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			rvld_q <= vld_q[req.addr];
			if (req.clear) begin
				vld_q <= '0;
			end else if (req.we) begin
				vld_q[req.addr] <= 1'b1;
			end
		end
	end

	// rows never written since the last clear read as empty
	assign rdata = rvld_q ? rdata_q : '0;

endmodule

### hdl/greedy_voxel_box_merger_core.sv
// channel   direction  handshake               payload
// item      in         item_valid/item_ready   item (kind, cell, solid, collidable)
// res       out        res_valid/res_ready     res (status, corner, sizes)
// apb       in/out     psel/penable/pready     paddr, pwdata, prdata (merge_enable)
// one item at a time; a load result is registered after the read, write and done
// states; clear and ignored items go to done directly; the next item follows the result
// pull: a scan of every row of the single-port row memory, an x growth state, then
// read/check per row tried in growth, read/write per row erased, all through the same port
// reset clears the row valid bits at once, so no clearing pass; clear items do the same
// a result waits in the output register; the next item is taken meanwhile, and its own
// result waits in the done state until the output register frees
module greedy_voxel_box_merger_core (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  gvbm_pkg::item_t   item,
	output logic              res_valid,
	input  logic              res_ready,
	output gvbm_pkg::result_t res,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [2:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import gvbm_pkg::*;

	typedef enum logic [11:0] {
		S_IDLE  = 12'b000000000001,
		S_LD_RD = 12'b000000000010,
		S_LD_WR = 12'b000000000100,
		S_SCAN  = 12'b000000001000,
		S_XGROW = 12'b000000010000,
		S_ZRD   = 12'b000000100000,
		S_ZCHK  = 12'b000001000000,
		S_YRD   = 12'b000010000000,
		S_YCHK  = 12'b000100000000,
		S_ERD   = 12'b001000000000,
		S_EWR   = 12'b010000000000,
		S_DONE  = 12'b100000000000
	} state_t;

	state_t            state_q;
	item_t             item_q;
	result_t           fin_q;
	result_t           res_q;
	logic              res_valid_q;
	logic              merge_q;
	logic [ADDR_W:0]   cnt_q;
	logic              scan_v_s1;
	logic [ADDR_W-1:0] scan_addr_s1;
	logic              found_q;
	logic [COORD_W-1:0] bx_q;
	logic [COORD_W-1:0] by_q;
	logic [COORD_W-1:0] bz_q;
	logic [ROW_W-1:0]  brow_q;
	logic [SIZE_W-1:0] ex_q;
	logic [SIZE_W-1:0] ey_q;
	logic [SIZE_W-1:0] ez_q;
	logic [SIZE_W-1:0] yi_q;
	logic [SIZE_W-1:0] zi_q;
	logic [ROW_W-1:0]  mask_q;

	mem_req_t          req;
	logic [WORD_W-1:0] rdata;
	logic              acc;
	logic [ROW_W-1:0]  ld_bit;
	logic [COORD_W:0]  lb;
	logic [SIZE_W-1:0] zsum;
	logic [SIZE_W-1:0] ysum;
	logic [SIZE_W-1:0] ex_new;
	logic              row_full;
	logic              cfg_wr;

	gvbm_row_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rdata  (rdata)
	);

	assign item_ready = (state_q == S_IDLE);
	assign acc        = item_valid && item_ready;
	assign res_valid  = res_valid_q;
	assign res        = res_q;
	assign pready     = 1'b1;
	assign prdata     = (paddr == REG_MERGE_ENABLE) ? {31'd0, merge_q} : 32'd0;
	assign cfg_wr     = psel && penable && pwrite;

	assign ld_bit   = ROW_W'(1) << item_q.cell_x;
	assign lb       = low_bit(rdata[ROW_W-1:0]);
	assign zsum     = {1'b0, bz_q} + ez_q;
	assign ysum     = {1'b0, by_q} + ey_q;
	assign ex_new   = merge_q ? run_len(brow_q, bx_q) : SIZE_W'(1);
	assign row_full = ((rdata[ROW_W-1:0] & mask_q) == mask_q);

	always_comb begin
		req = '0;
		req.clear = acc && (item.kind == KIND_CLEAR);
		unique case (state_q)
			S_LD_RD, S_LD_WR: begin
				req.addr = {item_q.cell_y, item_q.cell_z};
				if (state_q == S_LD_WR) begin
					req.we = !(|(rdata[WORD_W-1:ROW_W] & ld_bit));
					req.wdata = {rdata[WORD_W-1:ROW_W] | ld_bit,
						rdata[ROW_W-1:0] | (item_q.collidable ? ld_bit : '0)};
				end
			end
			S_SCAN:  req.addr = cnt_q[ADDR_W-1:0];
			S_ZRD:   req.addr = {by_q, zsum[COORD_W-1:0]};
			S_YRD:   req.addr = {ysum[COORD_W-1:0], bz_q + zi_q[COORD_W-1:0]};
			S_ERD, S_EWR: begin
				req.addr = {by_q + yi_q[COORD_W-1:0], bz_q + zi_q[COORD_W-1:0]};
				if (state_q == S_EWR) begin
					req.we = 1'b1;
					req.wdata = {rdata[WORD_W-1:ROW_W], rdata[ROW_W-1:0] & ~mask_q};
				end
			end
			default: req.addr = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			merge_q <= 1'b1;
		end else if (cfg_wr && paddr == REG_MERGE_ENABLE) begin
			merge_q <= pwdata[0];
		end
	end

	// scan compare on the returning row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_v_s1 <= 1'b0;
			found_q   <= 1'b0;
		end else begin
			scan_v_s1 <= (state_q == S_SCAN) && !cnt_q[ADDR_W];
			if (acc) begin
				found_q <= 1'b0;
			end else if (scan_v_s1 && lb[COORD_W] &&
				(!found_q || lb[COORD_W-1:0] < bx_q)) begin
				found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		scan_addr_s1 <= cnt_q[ADDR_W-1:0];
		if (scan_v_s1 && lb[COORD_W] && (!found_q || lb[COORD_W-1:0] < bx_q)) begin
			bx_q   <= lb[COORD_W-1:0];
			by_q   <= scan_addr_s1[ADDR_W-1:COORD_W];
			bz_q   <= scan_addr_s1[COORD_W-1:0];
			brow_q <= rdata[ROW_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			res_valid_q <= 1'b0;
			cnt_q       <= '0;
		end else begin
			if (state_q == S_DONE && (!res_valid_q || res_ready)) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (acc) begin
						item_q <= item;
						fin_q  <= '0;
						cnt_q  <= '0;
						if (item.kind == KIND_LOAD && item.solid) begin
							state_q <= S_LD_RD;
						end else if (item.kind == KIND_PULL) begin
							state_q <= S_SCAN;
						end else begin
							state_q <= S_DONE;
						end
					end
				end
				S_LD_RD: state_q <= S_LD_WR;
				S_LD_WR: begin
					if (!req.we) begin
						fin_q.status <= ST_DUP;
					end
					state_q <= S_DONE;
				end
				S_SCAN: begin
					if (!cnt_q[ADDR_W]) begin
						cnt_q <= cnt_q + (ADDR_W+1)'(1);
					end else if (!scan_v_s1) begin
						if (found_q) begin
							state_q <= S_XGROW;
						end else begin
							fin_q.status <= ST_NONE;
							state_q <= S_DONE;
						end
					end
				end
				S_XGROW: begin
					ex_q   <= ex_new;
					mask_q <= span(bx_q, ex_new);
					ey_q   <= SIZE_W'(1);
					ez_q   <= SIZE_W'(1);
					yi_q   <= '0;
					zi_q   <= '0;
					state_q <= merge_q ? S_ZRD : S_ERD;
				end
				S_ZRD: begin
					state_q <= zsum[COORD_W] ? S_YRD : S_ZCHK;
				end
				S_ZCHK: begin
					if (row_full) begin
						ez_q <= ez_q + SIZE_W'(1);
						state_q <= S_ZRD;
					end else begin
						state_q <= S_YRD;
					end
				end
				S_YRD: begin
					state_q <= ysum[COORD_W] ? S_ERD : S_YCHK;
					if (ysum[COORD_W]) begin
						zi_q <= '0;
					end
				end
				S_YCHK: begin
					if (!row_full) begin
						zi_q <= '0;
						state_q <= S_ERD;
					end else if (zi_q + SIZE_W'(1) == ez_q) begin
						ey_q <= ey_q + SIZE_W'(1);
						zi_q <= '0;
						state_q <= S_YRD;
					end else begin
						zi_q <= zi_q + SIZE_W'(1);
						state_q <= S_YRD;
					end
				end
				S_ERD: state_q <= S_EWR;
				S_EWR: begin
					if (zi_q + SIZE_W'(1) == ez_q) begin
						zi_q <= '0;
						if (yi_q + SIZE_W'(1) == ey_q) begin
							fin_q <= '{status: ST_OK, box_x: bx_q, box_y: by_q, box_z: bz_q,
								size_x: ex_q, size_y: ey_q, size_z: ez_q};
							state_q <= S_DONE;
						end else begin
							yi_q <= yi_q + SIZE_W'(1);
							state_q <= S_ERD;
						end
					end else begin
						zi_q <= zi_q + SIZE_W'(1);
						state_q <= S_ERD;
					end
				end
				S_DONE: begin
					if (!res_valid_q || res_ready) begin
						res_q   <= fin_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	a_write_states: assert property (@(posedge clk) disable iff (!arst_n)
		req.we |-> (state_q == S_LD_WR || state_q == S_EWR))
		else $error("row write outside load or erase");

	a_erase_in_box: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EWR) |-> (yi_q < ey_q && zi_q < ez_q))
		else $error("erase offset outside box");

	a_grow_has_corner: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XGROW) |-> found_q)
		else $error("growth without a corner cell");

	a_done_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && res_valid_q && !res_ready) |=> (state_q == S_DONE))
		else $error("result left done while output busy");

endmodule
